// ===== rtl/pli_pkg.sv =====
// Package for the positional list block: status codes, operation kinds,
// default depth and the command/status structs between controller and datapath.
// No dependencies.
`timescale 1ns / 1ps

package pli_pkg;

  // default list depth (entries)
  localparam int DEPTH_DEF = 64;

  // operation kinds carried in the kind field
  localparam logic [1:0] KIND_INSERT = 2'd0;
  localparam logic [1:0] KIND_DELETE = 2'd1;
  localparam logic [1:0] KIND_DUMP   = 2'd2;

  // result status codes
  typedef enum logic [1:0] {
    STAT_DONE   = 2'd0,
    STAT_REJECT = 2'd1,
    STAT_FULL   = 2'd2,
    STAT_EMPTY  = 2'd3
  } status_t;

  // controller state
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EXEC,
    ST_DUMP
  } state_t;

  // controller -> datapath commands
  typedef struct packed {
    logic latch;      // capture the accepted item
    logic apply;      // do insert/delete, load single result
    logic dump_step;  // load head entry as result, rotate the list
  } dp_cmd_t;

  // datapath -> controller status
  typedef struct packed {
    logic dump_go;    // item is a dump of a non-empty list
    logic dump_last;  // current dump step is the final entry
  } dp_sts_t;

endpackage

// ===== rtl/pli_in_if.sv =====
// Request channel interface: valid/ready handshake with kind, position, value.
// Depends on nothing.
`timescale 1ns / 1ps

interface pli_in_if;
  logic               valid;
  logic               ready;
  logic [1:0]         kind;
  logic [7:0]         position;
  logic signed [31:0] value;

  modport source (output valid, output kind, output position, output value, input ready);
  modport sink   (input valid, input kind, input position, input value, output ready);
endinterface

// ===== rtl/pli_out_if.sv =====
// Result channel interface: valid/ready handshake with status and dump entry.
// Depends on pli_pkg for the status type.
`timescale 1ns / 1ps

interface pli_out_if;
  logic               valid;
  logic               ready;
  pli_pkg::status_t   status;
  logic signed [31:0] entry_value;
  logic [6:0]         entry_position;
  logic               last;

  modport source (output valid, output status, output entry_value, output entry_position,
                  output last, input ready);
  modport sink   (input valid, input status, input entry_value, input entry_position,
                  input last, output ready);
endinterface

// ===== rtl/pli_ctrl.sv =====
// Controller for the positional list: sequences accept, execute and dump steps
// and owns the result valid flag. Depends on pli_pkg.
`timescale 1ns / 1ps

module pli_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              req_valid,
  output logic              req_ready,
  input  logic              rsp_ready,
  output logic              rsp_valid,
  input  pli_pkg::dp_sts_t  sts,
  output pli_pkg::dp_cmd_t  cmd
);
  import pli_pkg::*;

  state_t state;
  state_t state_next;
  logic   out_load;
  logic   out_free;

  // result register can take a new item
  assign out_free  = !rsp_valid || rsp_ready;
  assign req_ready = (state == ST_IDLE);

  // state register and result valid
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      rsp_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (out_load) begin
        rsp_valid <= 1'b1;
      end else if (rsp_ready) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  // next state and commands
  always_comb begin
    state_next    = state;
    cmd           = '0;
    out_load      = 1'b0;
    case (state)
      ST_IDLE: begin
        if (req_valid) begin
          cmd.latch  = 1'b1;
          state_next = ST_EXEC;
        end
      end
      ST_EXEC: begin
        if (out_free) begin
          out_load = 1'b1;
          if (sts.dump_go) begin
            cmd.dump_step = 1'b1;
            state_next    = sts.dump_last ? ST_IDLE : ST_DUMP;
          end else begin
            cmd.apply  = 1'b1;
            state_next = ST_IDLE;
          end
        end
      end
      ST_DUMP: begin
        if (out_free) begin
          out_load      = 1'b1;
          cmd.dump_step = 1'b1;
          if (sts.dump_last) begin
            state_next = ST_IDLE;
          end
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule

// ===== rtl/pli_dp.sv =====
// Datapath for the positional list: a row of entry registers that shift in
// parallel, the entry count, the dump index and the result register.
// Depends on pli_pkg.
`timescale 1ns / 1ps

module pli_dp #(
  parameter int DEPTH = pli_pkg::DEPTH_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  pli_pkg::dp_cmd_t   cmd,
  output pli_pkg::dp_sts_t   sts,
  input  logic [1:0]         req_kind,
  input  logic [7:0]         req_position,
  input  logic signed [31:0] req_value,
  output pli_pkg::status_t   rsp_status,
  output logic signed [31:0] rsp_entry_value,
  output logic [6:0]         rsp_entry_position,
  output logic               rsp_last
);
  import pli_pkg::*;

  localparam int CW = $clog2(DEPTH + 1);

  logic signed [31:0] entries [DEPTH];
  logic [CW-1:0]      count;
  logic [CW-1:0]      idx;
  logic [1:0]         op_kind;
  logic [7:0]         op_pos;
  logic signed [31:0] op_val;

  logic [7:0]         cnt8;
  logic [7:0]         p0;
  status_t            op_status;
  logic               ins_ok;
  logic               del_ok;
  logic [CW:0]        idx_inc;

  assign cnt8    = 8'(count);
  assign p0      = op_pos - 8'd1;
  assign idx_inc = {1'b0, idx} + {{CW{1'b0}}, 1'b1};

  // status of a single-result item
  always_comb begin
    op_status = STAT_REJECT;
    case (op_kind)
      KIND_INSERT: begin
        if (op_pos == 8'd0 || op_pos > cnt8 + 8'd1) begin
          op_status = STAT_REJECT;
        end else if (count == CW'(DEPTH)) begin
          op_status = STAT_FULL;
        end else begin
          op_status = STAT_DONE;
        end
      end
      KIND_DELETE: begin
        if (op_pos == 8'd0) begin
          op_status = STAT_REJECT;
        end else if (count == '0) begin
          op_status = STAT_EMPTY;
        end else if (op_pos > cnt8) begin
          op_status = STAT_REJECT;
        end else begin
          op_status = STAT_DONE;
        end
      end
      KIND_DUMP: begin
        op_status = STAT_DONE;
      end
      default: begin
        op_status = STAT_REJECT;
      end
    endcase
  end

  assign ins_ok = cmd.apply && (op_kind == KIND_INSERT) && (op_status == STAT_DONE);
  assign del_ok = cmd.apply && (op_kind == KIND_DELETE) && (op_status == STAT_DONE);

  assign sts.dump_go   = (op_kind == KIND_DUMP) && (count != '0);
  assign sts.dump_last = (idx_inc == {1'b0, count});

  // entry row: each cell takes its neighbour, the new value, or the head on rotation
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic signed [31:0] prev_val;
    logic signed [31:0] next_val;

    if (i == 0) begin : g_first
      assign prev_val = op_val;
    end else begin : g_mid
      assign prev_val = entries[i-1];
    end
    if (i == DEPTH - 1) begin : g_end
      assign next_val = entries[i];
    end else begin : g_more
      assign next_val = entries[i+1];
    end

    always_ff @(posedge clk) begin
      if (ins_ok) begin
        if (8'(i) == p0) begin
          entries[i] <= op_val;
        end else if (8'(i) > p0) begin
          entries[i] <= prev_val;
        end
      end else if (del_ok) begin
        if (8'(i) >= p0) begin
          entries[i] <= next_val;
        end
      end else if (cmd.dump_step) begin
        // rotate the occupied part by one so the head walks the list
        if ((CW'(i) + CW'(1)) == count) begin
          entries[i] <= entries[0];
        end else if ((CW'(i) + CW'(1)) < count) begin
          entries[i] <= next_val;
        end
      end
    end
  end

  // count and dump index
  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
      idx   <= '0;
    end else begin
      if (ins_ok) begin
        count <= count + CW'(1);
      end else if (del_ok) begin
        count <= count - CW'(1);
      end
      if (cmd.latch) begin
        idx <= '0;
      end else if (cmd.dump_step) begin
        idx <= idx_inc[CW-1:0];
      end
    end
  end

  // captured item and result register
  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      op_kind <= req_kind;
      op_pos  <= req_position;
      op_val  <= req_value;
    end
    if (cmd.apply) begin
      rsp_status         <= op_status;
      rsp_entry_value    <= '0;
      rsp_entry_position <= '0;
      rsp_last           <= 1'b1;
    end else if (cmd.dump_step) begin
      rsp_status         <= STAT_DONE;
      rsp_entry_value    <= entries[0];
      rsp_entry_position <= 7'(idx_inc);
      rsp_last           <= sts.dump_last;
    end
  end

endmodule

// ===== rtl/positional_list_insert_delete.sv =====
// Channel  Dir  Fields                                         Handshake
// req      in   kind[1:0] position[7:0] value[31:0] signed     valid/ready
// rsp      out  status[1:0] entry_value[31:0] entry_position[6:0] last  valid/ready
//
// Insert, delete and rejected items are captured, then executed: an accepted
// item shifts the entry row in parallel, and the result register is loaded.
// A dump gives one result per entry, the row rotating by one per result;
// a dump of an empty list gives a single result.
// Synchronous reset empties the list; entry contents are not cleared.
// A stalled result holds the controller; a new item is taken while the last
// result of the previous one still waits.
//
// Top level of the positional list. Depends on pli_pkg, pli_in_if, pli_out_if,
// pli_ctrl and pli_dp.
`timescale 1ns / 1ps

module positional_list_insert_delete #(
  parameter int DEPTH = pli_pkg::DEPTH_DEF
) (
  input  logic      clk,
  input  logic      rst,
  pli_in_if.sink    req,
  pli_out_if.source rsp
);
  import pli_pkg::*;

  dp_cmd_t cmd;
  dp_sts_t sts;

  // sequencing
  pli_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req.valid),
    .req_ready (req.ready),
    .rsp_ready (rsp.ready),
    .rsp_valid (rsp.valid),
    .sts       (sts),
    .cmd       (cmd)
  );

  // entry storage and result register
  pli_dp #(
    .DEPTH (DEPTH)
  ) u_dp (
    .clk                (clk),
    .rst                (rst),
    .cmd                (cmd),
    .sts                (sts),
    .req_kind           (req.kind),
    .req_position       (req.position),
    .req_value          (req.value),
    .rsp_status         (rsp.status),
    .rsp_entry_value    (rsp.entry_value),
    .rsp_entry_position (rsp.entry_position),
    .rsp_last           (rsp.last)
  );

endmodule

// ===== tb/sv/tb_positional_list_insert_delete.sv =====
// Self-checking testbench for positional_list_insert_delete: directed corner items,
// then random insert/delete/dump traffic with bursty requests and a stalling result side.
// Depends on pli_pkg, pli_in_if, pli_out_if and the positional list RTL.
`timescale 1ns / 1ps

module tb_positional_list_insert_delete;
  import pli_pkg::*;

  localparam int LIST_DEPTH = DEPTH_DEF;
  // kind 3 has no operation behind it; the block must reject it
  localparam logic [1:0] KIND_UNUSED = 2'd3;
  localparam int RANDOM_ITEMS = 150;
  localparam int DRAIN_CYCLES = 40;
  localparam longint TIMEOUT_NS = 20_000_000;

  typedef enum int {RX_FREE, RX_RANDOM, RX_THROTTLE} rx_mode_t;

  typedef struct packed {
    status_t     status;
    logic [31:0] value;
    logic [6:0]  position;
    logic        last;
  } list_result_t;

  // Mirror of the list plus the queue of results still owed by the block
  class list_scoreboard;
    logic signed [31:0] entry_q[$];
    list_result_t       owed_q[$];
    int                 errors = 0;

    function int count();
      return entry_q.size();
    endfunction

    function int pending();
      return owed_q.size();
    endfunction

    function void owe_single(status_t s);
      owed_q.push_back('{status: s, value: '0, position: '0, last: 1'b1});
    endfunction

    // work out every result that an accepted item causes
    function void note_item(logic [1:0] kind, logic [7:0] pos, logic signed [31:0] val);
      int n;
      n = entry_q.size();
      case (kind)
        KIND_INSERT: begin
          if (pos == 0 || pos > n + 1) owe_single(STAT_REJECT);
          else if (n >= LIST_DEPTH) owe_single(STAT_FULL);
          else begin
            entry_q.insert(pos - 1, val);
            owe_single(STAT_DONE);
          end
        end
        KIND_DELETE: begin
          if (pos == 0) owe_single(STAT_REJECT);
          else if (n == 0) owe_single(STAT_EMPTY);
          else if (pos > n) owe_single(STAT_REJECT);
          else begin
            entry_q.delete(pos - 1);
            owe_single(STAT_DONE);
          end
        end
        KIND_DUMP: begin
          if (n == 0) owe_single(STAT_DONE);
          for (int i = 0; i < n; i++) begin
            owed_q.push_back('{status: STAT_DONE, value: entry_q[i],
                               position: 7'(i + 1), last: (i == n - 1)});
          end
        end
        default: owe_single(STAT_REJECT);
      endcase
    endfunction

    function void compare_field(string name, longint exp_v, longint act_v);
      if (exp_v != act_v) begin
        $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, exp_v, act_v);
        errors++;
      end
    endfunction

    function void check_result(status_t status, logic signed [31:0] value,
                               logic [6:0] position, logic last);
      list_result_t exp_r;
      if (owed_q.size() == 0) begin
        $display("%0t: unexpected result, got status %0d value %0d position %0d last %0d",
                 $time, status, value, position, last);
        errors++;
        return;
      end
      exp_r = owed_q.pop_front();
      compare_field("status", exp_r.status, status);
      compare_field("entry_value", $signed(exp_r.value), value);
      compare_field("entry_position", exp_r.position, position);
      compare_field("last", exp_r.last, last);
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst;

  pli_in_if  req();
  pli_out_if rsp();

  positional_list_insert_delete dut (
    .clk (clk),
    .rst (rst),
    .req (req),
    .rsp (rsp)
  );

  list_scoreboard sb = new();

  int       burst_left = 0;
  int       stretch_left = 0;
  rx_mode_t stretch_mode = RX_FREE;

  always #6 clk = ~clk;

  // Result side: stretches of free flow, random stalls and a regular throttle
  always @(negedge clk) begin
    if (stretch_left == 0) begin
      stretch_mode = rx_mode_t'($urandom_range(0, 2));
      stretch_left = $urandom_range(8, 60);
    end
    stretch_left--;
    case (stretch_mode)
      RX_FREE:   rsp.ready <= 1'b1;
      RX_RANDOM: rsp.ready <= ($urandom_range(0, 1) == 1);
      default:   rsp.ready <= ((stretch_left % 7) < 2);
    endcase
  end

  // Check every accepted result
  always @(posedge clk) begin
    if (!rst && rsp.valid && rsp.ready) begin
      sb.check_result(rsp.status, rsp.entry_value, rsp.entry_position, rsp.last);
    end
  end

  // Drive one item, starting just after a falling edge; bursts with random gaps
  task automatic send_item(input logic [1:0] kind, input logic [7:0] pos,
                           input logic signed [31:0] val);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        req.valid <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      burst_left = $urandom_range(1, 12);
    end
    req.valid    <= 1'b1;
    req.kind     <= kind;
    req.position <= pos;
    req.value    <= val;
    do @(posedge clk); while (!req.ready);
    sb.note_item(kind, pos, val);
    burst_left--;
    @(negedge clk);
  endtask

  // Random traffic: grow the list until it has been full for a while, then drain it
  task automatic run_random(input int n_items);
    int          n;
    int          roll;
    int          full_seen;
    bit          growing;
    logic [1:0]  kind;
    logic [7:0]  pos;
    logic [31:0] val;
    growing   = 1'b1;
    full_seen = 0;
    repeat (n_items) begin
      n = sb.count();
      if (n == LIST_DEPTH) full_seen++;
      if (growing && full_seen >= 4) growing = 1'b0;
      if (!growing && n == 0) begin
        growing   = 1'b1;
        full_seen = 0;
      end
      roll = $urandom_range(0, 99);
      val  = $urandom();
      if (roll < 7) begin
        // noise: any kind, any position
        kind = 2'($urandom_range(0, 3));
        pos  = 8'($urandom_range(0, 255));
      end else if (roll < 12) begin
        kind = KIND_DUMP;
        pos  = 8'($urandom_range(0, 255));
      end else if ((roll < 92) == growing) begin
        kind = KIND_INSERT;
        pos  = 8'($urandom_range(1, n + 1));
      end else begin
        kind = KIND_DELETE;
        pos  = 8'((n == 0) ? $urandom_range(1, 255) : $urandom_range(1, n));
      end
      send_item(kind, pos, val);
    end
  endtask

  initial begin
    rst          = 1'b1;
    req.valid    = 1'b0;
    req.kind     = KIND_INSERT;
    req.position = '0;
    req.value    = '0;
    rsp.ready    = 1'b0;
    repeat (10) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // empty list corners
    send_item(KIND_DUMP,   8'd0,   32'sd0);
    send_item(KIND_DELETE, 8'd1,   32'sd5);
    send_item(KIND_DELETE, 8'd255, 32'sd5);
    send_item(KIND_DELETE, 8'd0,   32'sd5);
    send_item(KIND_INSERT, 8'd2,   32'sd7);
    send_item(KIND_INSERT, 8'd0,   32'sd7);
    // build a short list: first, front, end and middle
    send_item(KIND_INSERT, 8'd1,   32'sh7fff_ffff);
    send_item(KIND_INSERT, 8'd1,   32'sh8000_0000);
    send_item(KIND_INSERT, 8'd3,   -32'sd1);
    send_item(KIND_INSERT, 8'd2,   32'sd0);
    send_item(KIND_INSERT, 8'd255, 32'sd9);
    send_item(KIND_UNUSED, 8'd1,   32'sd9);
    send_item(KIND_DUMP,   8'd255, -32'sd1);
    // delete beyond the end, then middle, last and first
    send_item(KIND_DELETE, 8'd5,   32'sd0);
    send_item(KIND_DELETE, 8'd2,   32'sd0);
    send_item(KIND_DELETE, 8'd3,   32'sd0);
    send_item(KIND_DELETE, 8'd1,   32'sd0);
    send_item(KIND_DUMP,   8'd1,   32'sd0);
    send_item(KIND_UNUSED, 8'd0,   -32'sd1);
    send_item(KIND_DELETE, 8'd1,   32'sd0);
    send_item(KIND_DUMP,   8'd0,   32'sd0);

    run_random(RANDOM_ITEMS);
    req.valid <= 1'b0;

    // let the owed results arrive, then watch for strays
    while (sb.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (sb.errors == 0) begin
      $display("[positional_list_insert_delete] OK");
    end else begin
      $display("[positional_list_insert_delete] ERROR");
    end
    $finish;
  end

  // Watchdog against a hung handshake
  initial begin
    #(TIMEOUT_NS);
    $display("%0t: timeout with %0d results outstanding", $time, sb.pending());
    $display("[positional_list_insert_delete] ERROR");
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/pli_pkg.sv
rtl/pli_in_if.sv
rtl/pli_out_if.sv
rtl/pli_ctrl.sv
rtl/pli_dp.sv
rtl/positional_list_insert_delete.sv
tb/sv/tb_positional_list_insert_delete.sv
